// ===== rtl/hpb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hpb_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS   = 12;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_BITS     = 16;
    localparam int THRESH_BITS   = 17;
    localparam int CHANNEL_BITS  = 4;
    localparam int CFG_DATA_BITS = 17;

    // midi constants
    localparam logic [7:0]  PB_STATUS   = 8'hE0;
    localparam logic [14:0] BEND_CENTRE = 15'd8192;
    localparam logic [14:0] BEND_MAX    = 15'd16383;
    localparam int          BEND_SPAN   = 8191;

    // register reset values
    localparam logic [COEF_BITS-1:0]    POLE_RESET      = 16'd52429;
    localparam logic [THRESH_BITS-1:0]  THRESHOLD_RESET = 17'd5243;
    localparam logic [THRESH_BITS-1:0]  HYST_RESET      = 17'd655;
    localparam logic [CHANNEL_BITS-1:0] CHANNEL_RESET   = 4'd0;

    typedef enum logic [1:0] {
        CFG_POLE       = 2'd0,
        CFG_THRESHOLD  = 2'd1,
        CFG_HYSTERESIS = 2'd2,
        CFG_CHANNEL    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_near;
        logic [SAMPLE_BITS-1:0] sample_middle;
        logic [SAMPLE_BITS-1:0] sample_far;
    } sample_word_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] bend_low;
        logic [6:0] bend_high;
    } bend_word_t;

    typedef struct packed {
        logic [COEF_BITS-1:0]    pole_coefficient;
        logic [THRESH_BITS-1:0]  send_threshold;
        logic [THRESH_BITS-1:0]  hysteresis_band;
        logic [CHANNEL_BITS-1:0] midi_channel;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_MEAN,
        ST_FWD,
        ST_FBK,
        ST_ROUND,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RECIP,
        MUL_FWD,
        MUL_FBK,
        MUL_BEND
    } mul_op_t;

    typedef struct packed {
        logic    take_sample;
        mul_op_t mul_op;
        logic    make_mean;
        logic    save_acc;
        logic    update_filt;
        logic    decide;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic send;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/hall_pitch_bend_conditioner_unit.sv =====
// after acceptance: recip, mean, fwd, fbk, round, decide; emit loads a due message
// one sample word at a time, accepted only in idle; the single shared multiplier
//   serves the reciprocal divide, both filter taps and the bend scaling in turn
// a full output register that is not taken holds the next word in the emit state
// reset: asynchronous active low; filter state cleared, registers at defaults
`timescale 1ns / 1ps
`default_nettype none

module hall_pitch_bend_conditioner_unit #(
    parameter int FRAC_BITS = hpb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sample_valid,
    output logic                                    sample_ready,
    input  hpb_pkg::sample_word_t                   sample,
    output logic                                    bend_valid,
    input  wire logic                               bend_ready,
    output hpb_pkg::bend_word_t                     bend,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  hpb_pkg::cfg_index_t                     cfg_index,
    input  wire logic [hpb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import hpb_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POLE:       cfg_next.pole_coefficient = cfg_data[COEF_BITS-1:0];
                CFG_THRESHOLD:  cfg_next.send_threshold   = cfg_data[THRESH_BITS-1:0];
                CFG_HYSTERESIS: cfg_next.hysteresis_band  = cfg_data[THRESH_BITS-1:0];
                CFG_CHANNEL:    cfg_next.midi_channel     = cfg_data[CHANNEL_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pole_coefficient <= POLE_RESET;
            cfg_reg.send_threshold   <= THRESHOLD_RESET;
            cfg_reg.hysteresis_band  <= HYST_RESET;
            cfg_reg.midi_channel     <= CHANNEL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // sequencer
    hpb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .bend_valid   (bend_valid),
        .bend_ready   (bend_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // arithmetic
    hpb_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cfg    (cfg_reg),
        .cmd    (cmd),
        .status (status),
        .bend   (bend)
    );

endmodule

`default_nettype wire

// ===== rtl/hpb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hpb_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    output logic                    bend_valid,
    input  wire logic               bend_ready,
    input  hpb_pkg::dp_status_t     status,
    output hpb_pkg::dp_cmd_t        cmd
);
    import hpb_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_op   = MUL_NONE;
        sample_ready = 1'b0;

        // output word leaves when taken
        out_valid_next = out_valid_reg && !bend_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.take_sample = 1'b1;
                    state_next      = ST_RECIP;
                end
            end
            ST_RECIP:
            begin
                cmd.mul_op = MUL_RECIP;
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                cmd.make_mean = 1'b1;
                state_next    = ST_FWD;
            end
            ST_FWD:
            begin
                cmd.mul_op = MUL_FWD;
                state_next = ST_FBK;
            end
            ST_FBK:
            begin
                cmd.save_acc = 1'b1;
                cmd.mul_op   = MUL_FBK;
                state_next   = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.update_filt = 1'b1;
                state_next      = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                cmd.mul_op = MUL_BEND;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // wait for a free output register when a word is due
                if (!status.send)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || bend_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign bend_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/hpb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hpb_datapath #(
    parameter int FRAC_BITS = hpb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  hpb_pkg::sample_word_t     sample,
    input  hpb_pkg::cfg_t             cfg,
    input  hpb_pkg::dp_cmd_t          cmd,
    output hpb_pkg::dp_status_t       status,
    output hpb_pkg::bend_word_t       bend
);
    import hpb_pkg::*;

    // widths
    localparam int SUM_W = SAMPLE_BITS + 3;
    localparam int NUM_W = SUM_W + FRAC_BITS;
    localparam int T_W   = FRAC_BITS + 3;
    localparam int LVL_W = FRAC_BITS + 2;
    localparam int Q_W   = LVL_W - 1;
    localparam int AW    = FRAC_BITS + 4;
    localparam int BW    = (FRAC_BITS + 2 > COEF_BITS + 2) ? FRAC_BITS + 2 : COEF_BITS + 2;
    localparam int PW    = AW + BW;
    localparam int MAG_W = PW - COEF_BITS;
    localparam int CW    = ((LVL_W > THRESH_BITS) ? LVL_W : THRESH_BITS) + 1;
    localparam int DW    = (LVL_W + 1 > THRESH_BITS) ? LVL_W + 1 : THRESH_BITS;

    // constants
    localparam logic [NUM_W-1:0] MEAN_HALF = NUM_W'(3) << (SAMPLE_BITS - 1);
    localparam logic [BW-1:0]    RECIP_SIX = BW'((64'd1 << T_W) / 64'd6);
    localparam logic [PW-1:0]    COEF_HALF = PW'(1) << (COEF_BITS - 1);
    localparam logic [MAG_W-1:0] LVL_LIM   = MAG_W'(1) << (FRAC_BITS + 1);
    localparam logic [COEF_BITS:0] COEF_ONE = (COEF_BITS + 1)'(1) << COEF_BITS;

    logic [T_W-1:0]           t_reg, t_next;
    logic                     neg_reg, neg_next;
    logic signed [LVL_W-1:0]  mean_reg, mean_next;
    logic signed [PW-1:0]     prod_reg, prod_next;
    logic signed [PW-1:0]     acc_reg, acc_next;
    logic signed [LVL_W-1:0]  filt_reg, filt_next;
    logic signed [LVL_W-1:0]  last_reg, last_next;
    logic                     send_reg, send_next;
    bend_word_t               bend_reg, bend_next;

    // centring: invert the sample msb
    logic signed [SUM_W-1:0]  d_near, d_mid, d_far, sum;
    logic [SUM_W-1:0]         sum_mag;
    logic [NUM_W-1:0]         num;
    // quotient correction
    logic [Q_W-1:0]           q0, q;
    logic [T_W-1:0]           six_q0, rem;
    // multiplier operands
    logic signed [AW-1:0]     opa;
    logic signed [BW-1:0]     opb;
    // filter rounding
    logic signed [PW-1:0]     fsum;
    logic                     fneg;
    logic [PW-1:0]            fmag;
    logic [MAG_W-1:0]         frnd;
    logic signed [LVL_W-1:0]  y_sat;
    // send decision
    logic signed [LVL_W:0]    diff;
    logic [LVL_W:0]           diff_mag;
    logic                     send_now;
    // bend value
    logic [14:0]              bend_sum, bend_val;

    always_comb
    begin
        d_near = SUM_W'(signed'({~sample.sample_near[SAMPLE_BITS-1],
                                 sample.sample_near[SAMPLE_BITS-2:0]}));
        d_mid  = SUM_W'(signed'({~sample.sample_middle[SAMPLE_BITS-1],
                                 sample.sample_middle[SAMPLE_BITS-2:0]}));
        d_far  = SUM_W'(signed'({~sample.sample_far[SAMPLE_BITS-1],
                                 sample.sample_far[SAMPLE_BITS-2:0]}));
        sum     = (d_near <<< 1) + d_near + (d_mid <<< 1) + d_far;
        sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        num     = (NUM_W'(sum_mag) << FRAC_BITS) + MEAN_HALF;
    end

    // reciprocal quotient with one correction step
    always_comb
    begin
        q0     = prod_reg[T_W +: Q_W];
        six_q0 = (T_W'(q0) << 2) + (T_W'(q0) << 1);
        rem    = t_reg - six_q0;
        q      = (rem >= T_W'(6)) ? q0 + Q_W'(1) : q0;
    end

    // shared multiplier operand select
    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (cmd.mul_op)
            MUL_RECIP:
            begin
                opa = signed'(AW'(t_reg));
                opb = signed'(RECIP_SIX);
            end
            MUL_FWD:
            begin
                opa = AW'(mean_reg);
                opb = signed'(BW'(COEF_ONE - {1'b0, cfg.pole_coefficient}));
            end
            MUL_FBK:
            begin
                opa = AW'(filt_reg);
                opb = signed'(BW'(cfg.pole_coefficient));
            end
            MUL_BEND:
            begin
                opa = AW'(filt_reg);
                opb = BW'(BEND_SPAN);
            end
            MUL_NONE:
            begin
                opa = '0;
                opb = '0;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // filter output: round half away from zero, then saturate
    always_comb
    begin
        fsum = acc_reg + prod_reg;
        fneg = fsum[PW-1];
        fmag = fneg ? PW'(-fsum) : PW'(fsum);
        frnd = MAG_W'((fmag + COEF_HALF) >> COEF_BITS);
        if (!fneg && frnd > LVL_LIM - MAG_W'(1))
        begin
            y_sat = LVL_W'(LVL_LIM - MAG_W'(1));
        end
        else if (fneg && frnd > LVL_LIM)
        begin
            y_sat = LVL_W'(-signed'(LVL_LIM));
        end
        else if (fneg)
        begin
            y_sat = LVL_W'(-signed'(frnd));
        end
        else
        begin
            y_sat = LVL_W'(signed'(frnd));
        end
    end

    // threshold and hysteresis test
    always_comb
    begin
        diff     = (LVL_W + 1)'(filt_reg) - (LVL_W + 1)'(last_reg);
        diff_mag = diff[LVL_W] ? (LVL_W + 1)'(-diff) : (LVL_W + 1)'(diff);
        send_now = (CW'(filt_reg) > signed'(CW'(cfg.send_threshold)))
                && (DW'(diff_mag) > DW'(cfg.hysteresis_band));
    end

    // bend value from the scaled level
    always_comb
    begin
        bend_sum = BEND_CENTRE + {1'b0, prod_reg[FRAC_BITS +: 14]};
        bend_val = (bend_sum > BEND_MAX) ? BEND_MAX : bend_sum;
    end

    // register updates
    always_comb
    begin
        t_next    = t_reg;
        neg_next  = neg_reg;
        mean_next = mean_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        filt_next = filt_reg;
        last_next = last_reg;
        send_next = send_reg;
        bend_next = bend_reg;

        if (cmd.take_sample)
        begin
            t_next   = T_W'(num >> (SAMPLE_BITS - 1));
            neg_next = sum[SUM_W-1];
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_next = PW'(opa * opb);
        end
        if (cmd.make_mean)
        begin
            mean_next = neg_reg ? -signed'(LVL_W'(q)) : signed'(LVL_W'(q));
        end
        if (cmd.save_acc)
        begin
            acc_next = prod_reg;
        end
        if (cmd.update_filt)
        begin
            filt_next = y_sat;
        end
        if (cmd.decide)
        begin
            send_next = send_now;
            if (send_now)
            begin
                last_next = filt_reg;
            end
        end
        if (cmd.load_out)
        begin
            bend_next.status_byte = PB_STATUS | {4'd0, cfg.midi_channel};
            bend_next.bend_low    = bend_val[6:0];
            bend_next.bend_high   = bend_val[13:7];
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
            last_reg <= '0;
            send_reg <= 1'b0;
        end
        else
        begin
            filt_reg <= filt_next;
            last_reg <= last_next;
            send_reg <= send_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        bend_reg <= bend_next;
    end

    assign status.send = send_reg;
    assign bend        = bend_reg;

endmodule

`default_nettype wire

// ===== test/tb_hall_pitch_bend_conditioner_unit.sv =====
`timescale 1ns / 1ps

module tb_hall_pitch_bend_conditioner_unit;

    import hpb_pkg::*;

    localparam int     FRAC          = FRAC_BITS_DEF;
    localparam longint MID_SCALE     = longint'(1) << (SAMPLE_BITS - 1);
    localparam longint COEF_UNITY    = longint'(1) << COEF_BITS;
    localparam longint LEVEL_LIM     = longint'(1) << (FRAC + 1);
    localparam int     SETTLE_CYCLES = 24;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     PHASE_WORDS   = 205;
    localparam int     RANDOM_PHASES = 8;
    localparam longint CYCLE_LIMIT   = 500000;

    localparam cfg_index_t REG_ORDER [4] = '{CFG_POLE, CFG_THRESHOLD, CFG_HYSTERESIS,
                                             CFG_CHANNEL};

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     sample_valid;
    logic                     sample_ready;
    sample_word_t             sample;
    logic                     bend_valid;
    logic                     bend_ready;
    bend_word_t               bend;
    logic                     cfg_valid;
    logic                     cfg_ready;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // mirror of the block's registers and filter state
    logic [COEF_BITS-1:0]    pole_now;
    logic [THRESH_BITS-1:0]  thresh_now;
    logic [THRESH_BITS-1:0]  hyst_now;
    logic [CHANNEL_BITS-1:0] chan_now;
    logic signed [FRAC+1:0]  filt_level_now;
    logic signed [FRAC+1:0]  sent_level_now;

    bend_word_t bends_due [$];
    bend_word_t due_word;
    int         error_count = 0;
    longint     cycle_count = 0;

    // sender burst control
    int burst_left = 0;
    bit sender_idles = 1'b1;

    // receiver stall pattern and long hold-off
    bit         hold_request = 1'b0;
    int         hold_left = 0;
    logic [7:0] ready_pattern = 8'hFF;
    int         pattern_age = 0;

    hall_pitch_bend_conditioner_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .bend_valid   (bend_valid),
        .bend_ready   (bend_ready),
        .bend         (bend),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // nearest rounding, ties away from zero
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    // advance the filter by one sample word and return the bend word it sends, if any
    function automatic bit predict_bend(input sample_word_t w, output bend_word_t msg);
        longint offset_sum;
        longint mean_lvl;
        longint level;
        longint swing;
        longint bend_val;
        offset_sum = 3 * (longint'(w.sample_near) - MID_SCALE)
                   + 2 * (longint'(w.sample_middle) - MID_SCALE)
                   + (longint'(w.sample_far) - MID_SCALE);
        mean_lvl = round_div(offset_sum * (longint'(1) << FRAC), 6 * MID_SCALE);
        level = round_div((COEF_UNITY - longint'(pole_now)) * mean_lvl
                          + longint'(pole_now) * longint'(filt_level_now), COEF_UNITY);
        if (level > LEVEL_LIM - 1)
            level = LEVEL_LIM - 1;
        if (level < -LEVEL_LIM)
            level = -LEVEL_LIM;
        filt_level_now = level[FRAC+1:0];
        swing = level - longint'(sent_level_now);
        if (swing < 0)
            swing = -swing;
        msg = '0;
        if (!(level > longint'(thresh_now) && swing > longint'(hyst_now)))
            return 1'b0;
        sent_level_now = level[FRAC+1:0];
        bend_val = longint'(BEND_CENTRE) + (BEND_SPAN * level) / (longint'(1) << FRAC);
        if (bend_val > longint'(BEND_MAX))
            bend_val = longint'(BEND_MAX);
        if (bend_val < 0)
            bend_val = 0;
        msg.status_byte = PB_STATUS | {4'b0000, chan_now};
        msg.bend_low    = bend_val[6:0];
        msg.bend_high   = bend_val[13:7];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("error at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // compare each bend word taken with the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && bend_valid && bend_ready)
        begin
            if (bends_due.size() == 0)
                report_mismatch($sformatf("bend word %h with none due", bend));
            else
            begin
                due_word = bends_due.pop_front();
                if (bend.status_byte !== due_word.status_byte)
                    report_mismatch($sformatf("status_byte got %h want %h",
                                              bend.status_byte, due_word.status_byte));
                if (bend.bend_low !== due_word.bend_low)
                    report_mismatch($sformatf("bend_low got %h want %h",
                                              bend.bend_low, due_word.bend_low));
                if (bend.bend_high !== due_word.bend_high)
                    report_mismatch($sformatf("bend_high got %h want %h",
                                              bend.bend_high, due_word.bend_high));
            end
        end
    end

    // receiver: rotating ready pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (pattern_age == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 8'hFF;
                1: ready_pattern = 8'h01 << $urandom_range(0, 7);
                default: ready_pattern = 8'($urandom);
            endcase
            if (ready_pattern == 8'h00)
                ready_pattern = 8'h80;
            pattern_age = $urandom_range(16, 128);
        end
        pattern_age--;
        if (hold_left > 0)
        begin
            hold_left--;
            bend_ready <= 1'b0;
        end
        else
            bend_ready <= ready_pattern[pattern_age % 8];
    end

    // send one sample word, entered and left at a falling edge
    task automatic send_word(input sample_word_t w);
        bend_word_t msg;
        sample_valid <= 1'b1;
        sample <= w;
        do @(posedge clk); while (!sample_ready);
        if (predict_bend(w, msg))
            bends_due.push_back(msg);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else if (sender_idles)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    // let every due word drain and the pipeline empty
    task automatic wait_quiet();
        sample_valid <= 1'b0;
        while (bends_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // write all four registers back to back once the block is idle
    task automatic apply_settings(input logic [CFG_DATA_BITS-1:0] pole_data,
                                  input logic [CFG_DATA_BITS-1:0] thresh_data,
                                  input logic [CFG_DATA_BITS-1:0] hyst_data,
                                  input logic [CFG_DATA_BITS-1:0] chan_data);
        logic [CFG_DATA_BITS-1:0] reg_data [4];
        wait_quiet();
        reg_data[0] = pole_data;
        reg_data[1] = thresh_data;
        reg_data[2] = hyst_data;
        reg_data[3] = chan_data;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data <= reg_data[i];
            do @(posedge clk); while (!cfg_ready);
            case (REG_ORDER[i])
                CFG_POLE:       pole_now = reg_data[i][COEF_BITS-1:0];
                CFG_THRESHOLD:  thresh_now = reg_data[i][THRESH_BITS-1:0];
                CFG_HYSTERESIS: hyst_now = reg_data[i][THRESH_BITS-1:0];
                CFG_CHANNEL:    chan_now = reg_data[i][CHANNEL_BITS-1:0];
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // field extremes under the reset settings
    task automatic test_reset_defaults();
        sample_word_t words [10] = '{
            {12'd2048, 12'd2048, 12'd2048},
            {12'd0,    12'd0,    12'd0},
            {12'd4095, 12'd4095, 12'd4095},
            {12'd4095, 12'd4095, 12'd4095},
            {12'd4095, 12'd4095, 12'd4095},
            {12'd4095, 12'd4095, 12'd4095},
            {12'd4095, 12'd0,    12'd0},
            {12'd0,    12'd4095, 12'd4095},
            {12'd4095, 12'd4095, 12'd0},
            {12'd2049, 12'd2047, 12'd2048}
        };
        sender_idles = 1'b1;
        foreach (words[i])
            send_word(words[i]);
    endtask

    // register extremes, with junk above each register's width
    task automatic test_register_extremes();
        // no smoothing, no threshold, no band, top channel
        apply_settings({1'b1, 16'd0}, 17'd0, 17'd0, 17'h1FFFF);
        send_word({12'd4095, 12'd4095, 12'd4095});
        send_word({12'd2049, 12'd2048, 12'd2048});
        send_word({12'd2048, 12'd2048, 12'd2048});
        send_word({12'd0, 12'd0, 12'd0});
        send_word({12'd4095, 12'd4095, 12'd4095});
        // heaviest smoothing, level creeps up a step at a time
        apply_settings({1'b0, 16'hFFFF}, 17'd0, 17'd0, 17'd0);
        repeat (3) send_word({12'd4095, 12'd4095, 12'd4095});
        // threshold at full scale, nothing can pass
        apply_settings({1'b0, POLE_RESET}, 17'd65536, 17'd0, 17'd7);
        repeat (3) send_word({12'd4095, 12'd4095, 12'd4095});
        // band at full scale, nothing can move far enough
        apply_settings({1'b0, 16'd0}, 17'd0, 17'd65536, 17'd9);
        send_word({12'd4095, 12'd4095, 12'd4095});
        send_word({12'd0, 12'd0, 12'd0});
    endtask

    // long receiver hold-off while words keep coming, so the input stalls
    task automatic test_output_backpressure();
        sample_word_t w;
        apply_settings({1'b0, 16'd0}, 17'd0, 17'd0, 17'd5);
        sender_idles = 1'b0;
        burst_left = 0;
        @(posedge clk);
        hold_request = 1'b1;
        @(negedge clk);
        for (int n = 0; n < 24; n++)
        begin
            if (n % 2 == 0)
                w = {12'($urandom_range(3000, 4095)), 12'($urandom_range(3000, 4095)),
                     12'($urandom_range(3000, 4095))};
            else
                w = {12'($urandom_range(2300, 2900)), 12'($urandom_range(2300, 2900)),
                     12'($urandom_range(2300, 2900))};
            send_word(w);
        end
    endtask

    // one phase of random settings and mostly gesture-like sample streams
    task automatic run_random_phase(input int words);
        logic [CFG_DATA_BITS-1:0] pole_data;
        logic [CFG_DATA_BITS-1:0] thresh_data;
        logic [CFG_DATA_BITS-1:0] hyst_data;
        int           sent;
        int           span;
        int           lvl;
        int           start_lvl [3];
        int           end_lvl [3];
        logic [11:0]  pick [3];
        bit           noisy;
        sample_word_t w;
        case ($urandom_range(0, 5))
            0: pole_data[15:0] = 16'd0;
            1: pole_data[15:0] = 16'hFFFF;
            2: pole_data[15:0] = POLE_RESET;
            default: pole_data[15:0] = 16'($urandom);
        endcase
        pole_data[16] = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: thresh_data = 17'd0;
            1: thresh_data = 17'd65536;
            2: thresh_data = 17'($urandom_range(65537, 131071));
            default: thresh_data = 17'($urandom_range(0, 20000));
        endcase
        case ($urandom_range(0, 5))
            0: hyst_data = 17'd0;
            1: hyst_data = 17'd65536;
            2: hyst_data = 17'($urandom_range(0, 131071));
            default: hyst_data = 17'($urandom_range(0, 3000));
        endcase
        apply_settings(pole_data, thresh_data, hyst_data, 17'($urandom));
        sender_idles = ($urandom_range(0, 3) != 0);
        sent = 0;
        while (sent < words)
        begin
            span = $urandom_range(4, 40);
            noisy = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 3; k++)
            begin
                start_lvl[k] = $urandom_range(0, 4095);
                end_lvl[k] = ($urandom_range(0, 3) == 0) ? start_lvl[k] : $urandom_range(0, 4095);
            end
            for (int pos = 0; pos < span && sent < words; pos++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (noisy)
                        lvl = $urandom_range(0, 4095);
                    else
                        lvl = start_lvl[k] + (end_lvl[k] - start_lvl[k]) * pos / span
                            + int'($urandom_range(0, 64)) - 32;
                    if (lvl < 0)
                        lvl = 0;
                    if (lvl > 4095)
                        lvl = 4095;
                    pick[k] = 12'(lvl);
                end
                w = {pick[0], pick[1], pick[2]};
                send_word(w);
                sent++;
            end
        end
    endtask

    task automatic test_random_stream();
        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(PHASE_WORDS);
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POLE;
        cfg_data = '0;
        bend_ready = 1'b0;
        pole_now = POLE_RESET;
        thresh_now = THRESHOLD_RESET;
        hyst_now = HYST_RESET;
        chan_now = CHANNEL_RESET;
        filt_level_now = '0;
        sent_level_now = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_output_backpressure();
        test_random_stream();
        wait_quiet();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hpb_pkg.sv
rtl/hpb_ctrl.sv
rtl/hpb_datapath.sv
rtl/hall_pitch_bend_conditioner_unit.sv
test/tb_hall_pitch_bend_conditioner_unit.sv
